@@ design/pfba_pkg.sv @@
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

    localparam int PAGE_W = 16;
    localparam int WORD_BITS = 64;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC_NEXT = 2'd0,
        CMD_ALLOC_PAGE = 2'd1,
        CMD_FREE_PAGE  = 2'd2,
        CMD_QUERY      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NO_FREE   = 2'd3
    } t_status;

    // Lowest set bit of a nonzero word.
    function automatic logic [5:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/page_frame_bitmap_allocator.sv @@
// Page frame bitmap allocator: bitmap store, counters, hint and command sequencer.
// One command at a time: accept, S_READ, S_EXEC, then S_FIN loads the output register.
// Out of range or no usable hint: straight to S_FIN. Allocating the hinted page adds a forward
// scan through S_SCAN, S_SREAD and S_SEVAL per bitmap word visited, leaving S_SCAN at the limit.
// After reset every bitmap word is swept to all reserved, no command taken.
// Reset: free count 0, hint invalid, active_words 512.
module page_frame_bitmap_allocator #(
    parameter int MAX_PAGES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [14:0] i_page_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_result_page,
    output logic        o_page_was_free,
    output logic [15:0] o_free_pages,
    output logic [15:0] o_used_pages
);
    import pfba_pkg::*;

    localparam int MAP_WORDS = MAX_PAGES / 64;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int CMP_W     = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
    localparam int CAP_WORDS = (MAP_WORDS > 1023) ? 1023 : MAP_WORDS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN, S_SREAD, S_SEVAL, S_FIN
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_clr;
    logic [9:0]          r_active_words;
    logic [CNT_W-1:0]    r_free_count;
    logic [PAGE_W-1:0]   r_hint;
    logic                r_hint_valid;
    t_cmd                r_cmd;
    logic [PAGE_W-1:0]   r_page;
    logic [PAGE_W-1:0]   r_scan;
    t_status             r_st;
    logic [14:0]         r_rpage;
    logic                r_wf;

    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [9:0]           aw_eff;
    logic [PAGE_W-1:0]    limit;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 page_free;
    logic [WORD_BITS-1:0] avail;
    logic [CMP_W-1:0]     lim_ext;
    logic [CMP_W-1:0]     fc_ext;
    logic [15:0]          free_sat;
    logic [15:0]          used_cnt;

    assign aw_eff = (r_active_words > 10'(CAP_WORDS)) ? 10'(CAP_WORDS) : r_active_words;
    assign limit  = {aw_eff, 6'd0};

    assign bit_mask  = WORD_BITS'(1) << r_page[5:0];
    assign page_free = ~r_rdata[r_page[5:0]];
    assign avail     = ~r_rdata & (ALL_ONES << r_scan[5:0]);

    assign lim_ext  = CMP_W'(limit);
    assign fc_ext   = CMP_W'(r_free_count);
    assign free_sat = (fc_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : 16'(fc_ext);
    assign used_cnt = (lim_ext > fc_ext) ? 16'(lim_ext - fc_ext) : 16'd0;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = WORD_W'(r_page[15:6]);
        mem_wdata = r_rdata;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = ALL_ONES;
            end
            S_EXEC: begin
                if ((r_cmd == CMD_ALLOC_NEXT || r_cmd == CMD_ALLOC_PAGE) && page_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | bit_mask;
                end else if (r_cmd == CMD_FREE_PAGE && !page_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~bit_mask;
                end
            end
            S_SREAD: begin
                mem_addr = WORD_W'(r_scan[15:6]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_map[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_active_words <= 10'd512;
            r_free_count   <= '0;
            r_hint         <= '0;
            r_hint_valid   <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active_words <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WORD_W'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= t_cmd'(i_command);
                        r_wf  <= 1'b0;
                        if (t_cmd'(i_command) == CMD_ALLOC_NEXT) begin
                            r_page  <= r_hint;
                            r_rpage <= '0;
                            if (!r_hint_valid || r_hint >= limit) begin
                                r_st    <= ST_NO_FREE;
                                r_state <= S_FIN;
                            end else begin
                                r_st    <= ST_DONE;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_page  <= {1'b0, i_page_index};
                            r_rpage <= i_page_index;
                            if ({1'b0, i_page_index} >= limit) begin
                                r_st    <= ST_RANGE;
                                r_state <= S_FIN;
                            end else begin
                                r_st    <= ST_DONE;
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_wf <= page_free;
                    case (r_cmd)
                        CMD_ALLOC_NEXT, CMD_ALLOC_PAGE: begin
                            if (page_free) begin
                                r_rpage <= r_page[14:0];
                                if (r_free_count != '0) begin
                                    r_free_count <= r_free_count - 1'b1;
                                end
                                if (r_hint_valid && r_page == r_hint) begin
                                    r_hint_valid <= 1'b0;
                                    r_scan       <= r_page + 1'b1;
                                    r_state      <= S_SCAN;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end else if (r_cmd == CMD_ALLOC_NEXT) begin
                                r_st    <= ST_NO_FREE;
                                r_state <= S_FIN;
                            end else begin
                                r_st    <= ST_NO_CHANGE;
                                r_state <= S_FIN;
                            end
                        end
                        CMD_FREE_PAGE: begin
                            r_state <= S_FIN;
                            if (page_free) begin
                                r_st <= ST_NO_CHANGE;
                            end else begin
                                r_free_count <= r_free_count + 1'b1;
                                if (!r_hint_valid || r_page < r_hint) begin
                                    r_hint       <= r_page;
                                    r_hint_valid <= 1'b1;
                                end
                            end
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (r_scan >= limit) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SREAD;
                    end
                end
                S_SREAD: begin
                    r_state <= S_SEVAL;
                end
                S_SEVAL: begin
                    if (avail != '0) begin
                        r_hint       <= {r_scan[15:6], first_set(avail)};
                        r_hint_valid <= 1'b1;
                        r_state      <= S_FIN;
                    end else begin
                        r_scan  <= {r_scan[15:6] + 10'd1, 6'd0};
                        r_state <= S_SCAN;
                    end
                end
                S_FIN: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid     <= 1'b1;
                        o_status        <= r_st;
                        o_result_page   <= r_rpage;
                        o_page_was_free <= r_wf;
                        o_free_pages    <= free_sat;
                        o_used_pages    <= used_cnt;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/page_frame_bitmap_allocator_test.sv @@
// Self-checking testbench for the page frame bitmap allocator: directed table, then random phases.
module page_frame_bitmap_allocator_test;
    import pfba_pkg::*;

    localparam int MAX_PAGES = 32768;
    localparam int MAP_WORDS = MAX_PAGES / 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        t_status     status;
        logic [14:0] page;
        logic        was_free;
        logic [15:0] free_pg;
        logic [15:0] used_pg;
    } t_outcome;

    typedef struct {
        bit          is_cfg;
        logic [9:0]  cfg;
        t_cmd        cmd;
        logic [14:0] page;
        bit          typed;
        t_outcome    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [14:0] i_page_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [14:0] o_result_page;
    logic        o_page_was_free;
    logic [15:0] o_free_pages;
    logic [15:0] o_used_pages;

    page_frame_bitmap_allocator #(.MAX_PAGES(MAX_PAGES)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command(i_command),
        .i_page_index(i_page_index),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_result_page(o_result_page),
        .o_page_was_free(o_page_was_free),
        .o_free_pages(o_free_pages),
        .o_used_pages(o_used_pages)
    );

    // model state
    logic [63:0] frame_map [MAP_WORDS];
    int unsigned free_frames;
    int unsigned hint_page;
    bit          hint_ok;
    int unsigned cfg_words;

    t_outcome pending_results[$];
    t_row     stim_rows[$];
    int       errors;
    int       idle_cycles;
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_ask;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned active_limit();
        return ((cfg_words > MAP_WORDS) ? MAP_WORDS : cfg_words) * 64;
    endfunction

    function automatic bit frame_is_free(int unsigned pg);
        int unsigned w;
        w = pg >> 6;
        if (w >= MAP_WORDS) begin
            return 1'b0;
        end
        return !frame_map[w][pg & 63];
    endfunction

    function automatic void find_free_from(int unsigned start);
        int unsigned lim;
        int unsigned p;
        int unsigned w;
        int unsigned b;
        logic [63:0] avail;
        lim = active_limit();
        p = start;
        hint_ok = 1'b0;
        while (p < lim) begin
            w = p >> 6;
            avail = ~frame_map[w] & (ALL_ONES << (p & 63));
            if (avail != '0) begin
                b = 0;
                while (!avail[b]) begin
                    b++;
                end
                hint_page = w * 64 + b;
                hint_ok = 1'b1;
                return;
            end
            p = (w + 1) * 64;
        end
    endfunction

    function automatic void take_frame(int unsigned pg);
        frame_map[pg >> 6][pg & 63] = 1'b1;
        if (free_frames > 0) begin
            free_frames--;
        end
        if (hint_ok && pg == hint_page) begin
            find_free_from(pg + 1);
        end
    endfunction

    function automatic t_outcome predict_cmd(t_cmd c, logic [14:0] p);
        t_outcome r;
        int unsigned lim;
        int unsigned pg;
        int unsigned used;
        bit f;
        lim = active_limit();
        pg = p;
        r.status = ST_DONE;
        r.page = p;
        r.was_free = 1'b0;
        if (c == CMD_ALLOC_NEXT) begin
            if (!hint_ok || hint_page >= lim || !frame_is_free(hint_page)) begin
                r.status = ST_NO_FREE;
                r.page = '0;
            end else begin
                r.page = hint_page[14:0];
                r.was_free = 1'b1;
                take_frame(hint_page);
            end
        end else if (pg >= lim) begin
            r.status = ST_RANGE;
        end else begin
            f = frame_is_free(pg);
            r.was_free = f;
            case (c)
                CMD_ALLOC_PAGE: begin
                    if (f) begin
                        take_frame(pg);
                    end else begin
                        r.status = ST_NO_CHANGE;
                    end
                end
                CMD_FREE_PAGE: begin
                    if (f) begin
                        r.status = ST_NO_CHANGE;
                    end else begin
                        frame_map[pg >> 6][pg & 63] = 1'b0;
                        free_frames++;
                        if (!hint_ok || pg < hint_page) begin
                            hint_page = pg;
                            hint_ok = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        r.free_pg = (free_frames > 65535) ? 16'hFFFF : free_frames[15:0];
        used = (lim > free_frames) ? lim - free_frames : 0;
        r.used_pg = (used > 65535) ? 16'hFFFF : used[15:0];
        return r;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void row_cmd(t_cmd c, logic [14:0] p);
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg = '0;
        r.cmd = c;
        r.page = p;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_chk(t_cmd c, logic [14:0] p, t_status s, logic [14:0] rp,
                                    logic wf, logic [15:0] fp, logic [15:0] up);
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg = '0;
        r.cmd = c;
        r.page = p;
        r.typed = 1'b1;
        r.want.status = s;
        r.want.page = rp;
        r.want.was_free = wf;
        r.want.free_pg = fp;
        r.want.used_pg = up;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_cfg(logic [9:0] v);
        t_row r;
        r.is_cfg = 1'b1;
        r.cfg = v;
        r.cmd = CMD_QUERY;
        r.page = '0;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endfunction

    task automatic issue_cmd(input t_cmd c, input logic [14:0] p, input bit typed,
                             input t_outcome want, input int gap);
        t_outcome pred;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command <= c;
        i_page_index <= p;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_cmd(c, p);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_active_words(input logic [9:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_words = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result word checker
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = t_status'(o_status);
            got.page = o_result_page;
            got.was_free = o_page_was_free;
            got.free_pg = o_free_pages;
            got.used_pg = o_used_pages;
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report({$sformatf("got st=%0d pg=%0d wf=%0d free=%0d used=%0d",
                                      got.status, got.page, got.was_free, got.free_pg,
                                      got.used_pg),
                            $sformatf(" exp st=%0d pg=%0d wf=%0d free=%0d used=%0d",
                                      want.status, want.page, want.was_free, want.free_pg,
                                      want.used_pg)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("page_frame_bitmap_allocator regression: fail");
            $finish;
        end
    end

    // receiver
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask) begin
                hold_ask = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap(rx_idle_pct);
            end
        end
    end

    // sender
    initial begin
        int sent;
        int phase_len;
        int sel;
        int unsigned lim;
        int unsigned top;
        logic [9:0] words;
        logic [14:0] pg;
        t_cmd c;
        t_row row;
        bit held;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_QUERY;
        i_page_index = '0;
        errors = 0;
        idle_cycles = 0;
        hold_ask = 1'b0;
        held = 1'b0;
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        for (int i = 0; i < MAP_WORDS; i++) begin
            frame_map[i] = ALL_ONES;
        end
        free_frames = 0;
        hint_page = 0;
        hint_ok = 1'b0;
        cfg_words = 512;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        row_chk(CMD_QUERY,      15'd0,     ST_DONE,      15'd0,     1'b0, 16'd0, 16'd32768);
        row_chk(CMD_ALLOC_NEXT, 15'h7FFF,  ST_NO_FREE,   15'd0,     1'b0, 16'd0, 16'd32768);
        row_chk(CMD_ALLOC_PAGE, 15'd32767, ST_NO_CHANGE, 15'd32767, 1'b0, 16'd0, 16'd32768);
        row_chk(CMD_FREE_PAGE,  15'd32767, ST_DONE,      15'd32767, 1'b0, 16'd1, 16'd32767);
        row_chk(CMD_FREE_PAGE,  15'd32767, ST_NO_CHANGE, 15'd32767, 1'b1, 16'd1, 16'd32767);
        row_chk(CMD_FREE_PAGE,  15'd0,     ST_DONE,      15'd0,     1'b0, 16'd2, 16'd32766);
        row_chk(CMD_ALLOC_NEXT, 15'd12345, ST_DONE,      15'd0,     1'b1, 16'd1, 16'd32767);
        row_chk(CMD_ALLOC_NEXT, 15'd0,     ST_DONE,      15'd32767, 1'b1, 16'd0, 16'd32768);
        row_chk(CMD_ALLOC_NEXT, 15'h5555,  ST_NO_FREE,   15'd0,     1'b0, 16'd0, 16'd32768);
        row_chk(CMD_FREE_PAGE,  15'd64,    ST_DONE,      15'd64,    1'b0, 16'd1, 16'd32767);
        row_chk(CMD_FREE_PAGE,  15'd70,    ST_DONE,      15'd70,    1'b0, 16'd2, 16'd32766);
        row_chk(CMD_ALLOC_PAGE, 15'd70,    ST_DONE,      15'd70,    1'b1, 16'd1, 16'd32767);
        row_chk(CMD_ALLOC_PAGE, 15'd64,    ST_DONE,      15'd64,    1'b1, 16'd0, 16'd32768);
        row_cmd(CMD_FREE_PAGE,  15'd127);
        row_cmd(CMD_FREE_PAGE,  15'd200);
        row_cfg(10'd1);
        row_chk(CMD_QUERY,      15'd64,    ST_RANGE,     15'd64,    1'b0, 16'd2, 16'd62);
        row_chk(CMD_ALLOC_NEXT, 15'd0,     ST_NO_FREE,   15'd0,     1'b0, 16'd2, 16'd62);
        row_cmd(CMD_QUERY,      15'd63);
        row_cfg(10'd0);
        row_chk(CMD_QUERY,      15'd0,     ST_RANGE,     15'd0,     1'b0, 16'd2, 16'd0);
        row_chk(CMD_FREE_PAGE,  15'd0,     ST_RANGE,     15'd0,     1'b0, 16'd2, 16'd0);
        row_cfg(10'd1023);
        row_cmd(CMD_ALLOC_NEXT, 15'h2AAA);
        row_cmd(CMD_QUERY,      15'd200);
        row_cfg(10'd512);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.is_cfg) begin
                wait_results_drained();
                write_active_words(row.cfg);
            end else begin
                issue_cmd(row.cmd, row.page, row.typed, row.want, pick_gap(tx_idle_pct));
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_results_drained();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                words = 10'd512;
            end else if (sel < 8) begin
                words = 10'($urandom_range(513, 1023));
            end else if (sel < 11) begin
                words = 10'($urandom_range(9, 511));
            end else if (sel < 13) begin
                words = 10'd0;
            end else begin
                words = 10'($urandom_range(1, 8));
            end
            write_active_words(words);
            phase_len = (words > 8) ? $urandom_range(10, 25) : $urandom_range(20, 60);
            tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            lim = active_limit();
            top = (lim == 0) ? 15 : lim + 15;
            if (top > 32767) begin
                top = 32767;
            end
            if (!held && sent >= 500) begin
                held = 1'b1;
                hold_ask = 1'b1;
            end
            repeat (phase_len) begin
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    c = CMD_FREE_PAGE;
                end else if (sel < 60) begin
                    c = CMD_ALLOC_NEXT;
                end else if (sel < 80) begin
                    c = CMD_ALLOC_PAGE;
                end else begin
                    c = CMD_QUERY;
                end
                if ($urandom_range(0, 99) < 15) begin
                    pg = 15'($urandom_range(0, 32767));
                end else begin
                    pg = 15'($urandom_range(0, top));
                end
                issue_cmd(c, pg, 1'b0, '0, pick_gap(tx_idle_pct));
                sent++;
            end
        end

        wait_results_drained();
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("page_frame_bitmap_allocator regression: pass");
        end else begin
            $display("page_frame_bitmap_allocator regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/pfba_pkg.sv
design/page_frame_bitmap_allocator.sv
tb/sv/page_frame_bitmap_allocator_test.sv
